FILE: rtl/lhr_pkg.sv
// ----------------------------------------------------------------------------
// lhr_pkg
// Shared types, constants and helpers for the link handshake retry controller
// ----------------------------------------------------------------------------
`default_nettype none

package lhr_pkg;

  localparam int unsigned RETRY_W      = 8;
  localparam int unsigned INTERVAL_W   = 20;
  localparam int unsigned BLINK_W      = 8;
  localparam int unsigned ADDR_W       = 16;
  localparam int unsigned RSSI_W       = 9;
  localparam int unsigned SNR_W        = 8;
  localparam int unsigned PCT_W        = 7;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned OUT_TDATA_W  = 56;

  localparam logic [BLINK_W-1:0]    SLOW_BLINK_TICKS_DEF = 8'd250;
  localparam logic [BLINK_W-1:0]    FAST_BLINK_TICKS_DEF = 8'd75;
  localparam logic [RETRY_W-1:0]    MAX_RETRIES_RST      = 8'd5;
  localparam logic [INTERVAL_W-1:0] RETRY_INTERVAL_RST   = 20'd3000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 8'd1;

  // rssi mapping: clamp to -100..-30 dBm, then scale 0..70 to 0..100
  localparam logic signed [RSSI_W:0] RSSI_OFS   = 10'sd100;
  localparam logic signed [RSSI_W:0] RSSI_SPAN  = 10'sd70;
  localparam int unsigned            RSSI_SHIFT = 14;
  localparam logic [14:0]            RSSI_RECIP = 15'd23410;

  typedef enum logic [1:0] {
    MODE_SEARCHING = 2'd0,
    MODE_LOCKED    = 2'd1,
    MODE_FAILED    = 2'd2
  } link_mode_e;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_FRAME = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [RETRY_W-1:0]    max_retries;
    logic [INTERVAL_W-1:0] retry_interval;
  } cfg_t;

  typedef struct packed {
    cmd_e                     cmd;
    logic [ADDR_W-1:0]        sender_id;
    logic                     is_pong;
    logic signed [RSSI_W-1:0] raw_rssi;
    logic signed [SNR_W-1:0]  snr;
  } item_t;

  typedef struct packed {
    logic                    send_ping;
    logic                    led_write;
    logic                    led_first;
    logic                    led_second;
    link_mode_e              link_state;
    logic [ADDR_W-1:0]       locked_addr;
    logic                    deliver_data;
    logic [ADDR_W-1:0]       sender_out;
    logic [PCT_W-1:0]        rssi_pct;
    logic signed [SNR_W-1:0] snr_out;
  } result_t;

  function automatic logic [PCT_W-1:0] rssi_percent(logic signed [RSSI_W-1:0] dbm);
    logic signed [RSSI_W:0] ofs;
    logic [PCT_W-1:0]       lin;
    logic [21:0]            prod;
    ofs = $signed({dbm[RSSI_W-1], dbm}) + RSSI_OFS;
    if (ofs < 10'sd0) begin
      lin = '0;
    end else if (ofs > RSSI_SPAN) begin
      lin = PCT_W'(RSSI_SPAN);
    end else begin
      lin = ofs[PCT_W-1:0];
    end
    // times 10/7 by reciprocal, exact over 0..70
    prod = 22'(lin) * 22'(RSSI_RECIP);
    return prod[RSSI_SHIFT +: PCT_W];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lhr_cfg_regs.sv
// ----------------------------------------------------------------------------
// lhr_cfg_regs
// Configuration register file: retry limit and retry interval
// ----------------------------------------------------------------------------
`default_nettype none

module lhr_cfg_regs
  import lhr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_RETRIES:    cfg_d.max_retries    = cfg_data_i[RETRY_W-1:0];
        CFG_RETRY_INTERVAL: cfg_d.retry_interval = cfg_data_i[INTERVAL_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_retries    <= MAX_RETRIES_RST;
      cfg_q.retry_interval <= RETRY_INTERVAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/lhr_link_ctrl.sv
// ----------------------------------------------------------------------------
// lhr_link_ctrl
// Link state machine, ping retry timer, led blinker and frame bookkeeping
// ----------------------------------------------------------------------------
`default_nettype none

module lhr_link_ctrl
  import lhr_pkg::*;
#(
  parameter logic [BLINK_W-1:0] SLOW_BLINK_TICKS = SLOW_BLINK_TICKS_DEF,
  parameter logic [BLINK_W-1:0] FAST_BLINK_TICKS = FAST_BLINK_TICKS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output result_t    result_o
);

  link_mode_e              mode_q, mode_d;
  logic [RETRY_W-1:0]      retries_q, retries_d;
  logic [INTERVAL_W-1:0]   ping_el_q, ping_el_d, ping_el_inc;
  logic                    ever_q, ever_d;
  logic [BLINK_W-1:0]      blink_el_q, blink_el_d, blink_el_inc, period;
  logic                    phase_q, phase_d;
  logic [ADDR_W-1:0]       gw_q, gw_d;
  logic [PCT_W-1:0]        pct_q, pct_d;
  logic signed [SNR_W-1:0] snr_q, snr_d;
  logic                    ping, ledw, deliver, ping_due;
  logic [ADDR_W-1:0]       sender;

  assign ping_el_inc  = (ping_el_q != '1) ? ping_el_q + 1'b1 : ping_el_q;
  assign blink_el_inc = (blink_el_q != '1) ? blink_el_q + 1'b1 : blink_el_q;
  assign ping_due     = !ever_q || (ping_el_inc >= cfg_i.retry_interval);

  always_comb begin
    mode_d     = mode_q;
    retries_d  = retries_q;
    ping_el_d  = ping_el_q;
    ever_d     = ever_q;
    blink_el_d = blink_el_q;
    phase_d    = phase_q;
    gw_d       = gw_q;
    pct_d      = pct_q;
    snr_d      = snr_q;
    ping       = 1'b0;
    ledw       = 1'b0;
    deliver    = 1'b0;
    sender     = '0;
    period     = SLOW_BLINK_TICKS;

    if (item_i.cmd == CMD_TICK) begin
      ping_el_d  = ping_el_inc;
      blink_el_d = blink_el_inc;
      unique case (mode_q)
        MODE_SEARCHING: begin
          if (ping_due) begin
            if (retries_q < cfg_i.max_retries) begin
              ping      = 1'b1;
              ping_el_d = '0;
              retries_d = retries_q + 1'b1;
              ever_d    = 1'b1;
            end else begin
              mode_d = MODE_FAILED;
            end
          end
        end
        MODE_LOCKED, MODE_FAILED: ;
        default: ;
      endcase
      if (mode_d != MODE_LOCKED) begin
        period = (mode_d == MODE_FAILED) ? FAST_BLINK_TICKS : SLOW_BLINK_TICKS;
        if (blink_el_inc >= period) begin
          blink_el_d = '0;
          phase_d    = ~phase_q;
          ledw       = 1'b1;
        end
      end
    end else begin
      pct_d = rssi_percent(item_i.raw_rssi);
      snr_d = item_i.snr;
      if (item_i.is_pong && (mode_q == MODE_SEARCHING)) begin
        gw_d   = item_i.sender_id;
        mode_d = MODE_LOCKED;
      end else begin
        deliver = 1'b1;
        sender  = item_i.sender_id;
      end
    end

    result_o.send_ping    = ping;
    result_o.led_write    = ledw;
    result_o.led_first    = phase_d;
    result_o.led_second   = ~phase_d;
    result_o.link_state   = mode_d;
    result_o.locked_addr  = gw_d;
    result_o.deliver_data = deliver;
    result_o.sender_out   = sender;
    result_o.rssi_pct     = pct_d;
    result_o.snr_out      = snr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_SEARCHING;
      retries_q  <= '0;
      ping_el_q  <= '0;
      ever_q     <= 1'b0;
      blink_el_q <= '0;
      phase_q    <= 1'b0;
      gw_q       <= '0;
      pct_q      <= '0;
      snr_q      <= '0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      retries_q  <= retries_d;
      ping_el_q  <= ping_el_d;
      ever_q     <= ever_d;
      blink_el_q <= blink_el_d;
      phase_q    <= phase_d;
      gw_q       <= gw_d;
      pct_q      <= pct_d;
      snr_q      <= snr_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/link_handshake_retry_fsm.sv
// ----------------------------------------------------------------------------
// link_handshake_retry_fsm
// Radio link handshake controller: ping retries, led blink, gateway lock
// ----------------------------------------------------------------------------
//   channel   direction  handshake               payload
//   s_axis    in         s_axis_tvalid/tready    tick or received frame
//   m_axis    out        m_axis_tvalid/tready    one result beat per input beat
//   cfg       in         cfg_valid_i/ready_o     register index and value
//
// one beat per cycle sustained while m_axis_tready stays high; a result beat
// passes through the input register, one pass of state logic and the result
// register once its input beat is taken
// reset puts the link in searching with retry limit 5 and interval 3000 ticks
// a stalled result holds the pipe; s_axis_tready falls only when both stages
// are full and m_axis_tready is low
`default_nettype none

module link_handshake_retry_fsm
  import lhr_pkg::*;
#(
  parameter logic [BLINK_W-1:0] SLOW_BLINK_TICKS = SLOW_BLINK_TICKS_DEF,
  parameter logic [BLINK_W-1:0] FAST_BLINK_TICKS = FAST_BLINK_TICKS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // sender_id, is_pong, raw_rssi, snr, zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // send_ping, led_write, led_first, led_second, link_state, locked_addr,
  // deliver_data, sender_out, rssi_pct, snr_out, zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t    cfg;
  item_t   in_item_q, in_item_d;
  logic    in_valid_q, in_valid_d;
  result_t res, out_q;
  logic    out_valid_q, out_valid_d;
  logic    advance, load;

  lhr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lhr_link_ctrl #(
    .SLOW_BLINK_TICKS (SLOW_BLINK_TICKS),
    .FAST_BLINK_TICKS (FAST_BLINK_TICKS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_item_d.cmd       = cmd_e'(s_axis_tuser);
    in_item_d.sender_id = s_axis_tdata[15:0];
    in_item_d.is_pong   = s_axis_tdata[16];
    in_item_d.raw_rssi  = $signed(s_axis_tdata[25:17]);
    in_item_d.snr       = $signed(s_axis_tdata[33:26]);
    if (load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_item_q <= in_item_d;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00,
                          out_q.snr_out,
                          out_q.rssi_pct,
                          out_q.sender_out,
                          out_q.deliver_data,
                          out_q.locked_addr,
                          out_q.link_state,
                          out_q.led_second,
                          out_q.led_first,
                          out_q.led_write,
                          out_q.send_ping};

endmodule

`default_nettype wire
